@@ hw/rtl/mjs_pkg.sv @@
// Package for the multi-policy job scheduler.
// Holds the beat types, opcodes, policy codes, register indexes and defaults.
// No dependencies.
`default_nettype none

package mjs_pkg;

    localparam int SLOT_FIELD_W   = 4;
    localparam int BURST_FIELD_W  = 24;
    localparam int POLICY_W       = 2;
    localparam int QUANTUM_W      = 16;
    localparam int TOTAL_W        = 5;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;

    localparam int DEF_MAX_JOBS   = 16;
    localparam int DEF_BURST_BITS = 24;

    localparam logic [QUANTUM_W-1:0] DEF_QUANTUM = QUANTUM_W'(500);

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [POLICY_W-1:0] MODE_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] MODE_RR   = 2'd1;
    localparam logic [POLICY_W-1:0] MODE_SJF  = 2'd2;
    localparam logic [POLICY_W-1:0] MODE_PSJF = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL   = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic [BURST_FIELD_W-1:0] burst_length;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    slot_valid;
        logic                    table_full;
        logic                    finished;
        logic [SLOT_FIELD_W-1:0] finished_slot;
        logic                    switched;
        logic                    all_done;
    } t_out_beat;

    typedef struct packed {
        logic clear;
        logic go;
        logic first_only;
    } t_scan_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/mjs_scan.sv @@
// Shared compare unit of the job scheduler: tracks the first or the shortest job.
// Takes one slot per cycle from the sequencer. Depends on mjs_pkg.
`default_nettype none

module mjs_scan #(
    parameter int MAX_JOBS   = mjs_pkg::DEF_MAX_JOBS,
    parameter int BURST_BITS = mjs_pkg::DEF_BURST_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mjs_pkg::t_scan_ctl            i_ctl,
    input  wire logic [$clog2(MAX_JOBS)-1:0]   i_idx,
    input  wire logic                          i_used,
    input  wire logic [BURST_BITS-1:0]         i_value,
    output logic                               o_found,
    output logic [$clog2(MAX_JOBS)-1:0]        o_best
);
    import mjs_pkg::*;

    localparam int SLOT_W = $clog2(MAX_JOBS);

    logic                  r_found;
    logic [SLOT_W-1:0]     r_best;
    logic [BURST_BITS-1:0] r_best_val;
    logic                  candidate;
    logic                  take;

    assign candidate = i_ctl.go && i_used && (i_value != '0);
    assign take      = candidate && (!r_found || (!i_ctl.first_only && (i_value < r_best_val)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_best <= '0;
        end else if (take) begin
            r_best     <= i_idx;
            r_best_val <= i_value;
        end
    end

    assign o_found = r_found;
    assign o_best  = r_best;

endmodule

`default_nettype wire

@@ hw/rtl/mjs_core.sv @@
// Sequencer of the job scheduler with the burst memory, the round robin ring
// and the job table flags. Uses mjs_scan for the slot walk. Depends on mjs_pkg.
`default_nettype none

module mjs_core #(
    parameter int MAX_JOBS   = mjs_pkg::DEF_MAX_JOBS,
    parameter int BURST_BITS = mjs_pkg::DEF_BURST_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire mjs_pkg::t_in_beat               i_in_beat,
    input  wire logic [mjs_pkg::POLICY_W-1:0]    i_policy,
    input  wire logic [mjs_pkg::QUANTUM_W-1:0]   i_quantum,
    input  wire logic [mjs_pkg::TOTAL_W-1:0]     i_job_total,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output mjs_pkg::t_out_beat                   o_res
);
    import mjs_pkg::*;

    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int DONE_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_JOBS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_JOBS);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_FIN   = 4'd1;
    localparam logic [ST_W-1:0] ST_RQ1   = 4'd2;
    localparam logic [ST_W-1:0] ST_RQ2   = 4'd3;
    localparam logic [ST_W-1:0] ST_SCAN  = 4'd4;
    localparam logic [ST_W-1:0] ST_SEND  = 4'd5;
    localparam logic [ST_W-1:0] ST_SRES  = 4'd6;
    localparam logic [ST_W-1:0] ST_APPLY = 4'd7;
    localparam logic [ST_W-1:0] ST_DEC   = 4'd8;
    localparam logic [ST_W-1:0] ST_OUT   = 4'd9;

    logic [BURST_BITS-1:0] mem_rt [MAX_JOBS];
    logic [SLOT_W-1:0]     mem_rq [MAX_JOBS];

    logic [ST_W-1:0]       r_state, n_state;
    logic [MAX_JOBS-1:0]   r_used;
    logic [SLOT_W-1:0]     r_q_head;
    logic [SLOT_W-1:0]     r_q_tail;
    logic [CNT_W-1:0]      r_q_count;
    logic [SLOT_W-1:0]     r_active_slot;
    logic                  r_active_valid;
    logic [QUANTUM_W-1:0]  r_since;
    logic [CNT_W-1:0]      r_jobs_loaded;
    logic [CNT_W-1:0]      r_jobs_done;
    logic [SLOT_W-1:0]     r_scan;
    logic                  r_cmp_go;
    logic                  r_rot_done;
    logic                  r_run;
    logic [SLOT_W-1:0]     r_pick;
    logic [SLOT_W-1:0]     r_cmp_idx;
    logic [BURST_BITS-1:0] r_rd;
    logic [SLOT_W-1:0]     r_ring;
    t_out_beat             r_res;

    logic [BURST_BITS-1:0] burst;
    logic                  accept;
    logic                  is_tick;
    logic                  arr_ok;
    logic                  q_full;
    logic [SLOT_W-1:0]     slot_new;
    logic                  retire;
    logic                  act_post;
    logic                  rotate;
    logic                  all_done_now;
    logic                  switched;
    logic [SLOT_W-1:0]     new_slot;
    logic                  rt_we;
    logic [SLOT_W-1:0]     rt_waddr;
    logic [BURST_BITS-1:0] rt_wdata;
    logic [SLOT_W-1:0]     rt_raddr;
    logic                  rq_we;
    logic [SLOT_W-1:0]     rq_wdata;
    t_scan_ctl             scan_ctl;
    logic                  scan_found;
    logic [SLOT_W-1:0]     scan_best;
    t_out_beat             idle_res;

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] v);
        return (v == LAST_SLOT) ? '0 : SLOT_W'(v + SLOT_W'(1));
    endfunction

    assign burst        = BURST_BITS'(i_in_beat.burst_length);
    assign accept       = i_in_valid && (r_state == ST_IDLE);
    assign is_tick      = (i_in_beat.opcode == OP_TICK);
    assign arr_ok       = accept && !is_tick && (burst != '0) && (r_jobs_loaded != FULL_CNT);
    assign q_full       = (r_q_count == FULL_CNT);
    assign slot_new     = r_jobs_loaded[SLOT_W-1:0];
    assign retire       = r_active_valid && (r_rd == '0);
    assign act_post     = r_active_valid && !retire;
    assign rotate       = r_active_valid && (r_q_count != '0) && (r_since >= i_quantum)
                          && !r_rot_done;
    assign all_done_now = DONE_W'(r_jobs_done) >= DONE_W'(i_job_total);
    assign switched     = (r_run != r_active_valid) || (r_run && (r_pick != r_active_slot));
    assign new_slot     = r_run ? r_pick : '0;

    always_comb begin
        idle_res          = '0;
        idle_res.all_done = all_done_now;
        if (!is_tick && (burst != '0)) begin
            if (r_jobs_loaded == FULL_CNT) begin
                idle_res.table_full = 1'b1;
            end else begin
                idle_res.slot       = SLOT_FIELD_W'(slot_new);
                idle_res.slot_valid = 1'b1;
            end
        end
    end

    always_comb begin
        rt_we    = arr_ok;
        rt_waddr = slot_new;
        rt_wdata = burst;
        if (r_state == ST_DEC) begin
            rt_we    = r_active_valid && (r_rd != '0);
            rt_waddr = r_active_slot;
            rt_wdata = BURST_BITS'(r_rd - BURST_BITS'(1));
        end
    end

    always_comb begin
        unique case (r_state)
            ST_SCAN:  rt_raddr = r_scan;
            ST_APPLY: rt_raddr = new_slot;
            default:  rt_raddr = r_active_slot;
        endcase
    end

    assign rq_we    = (arr_ok && (i_policy == MODE_RR) && !q_full)
                      || ((r_state == ST_RQ2) && rotate);
    assign rq_wdata = (r_state == ST_RQ2) ? r_ring : slot_new;

    always_ff @(posedge i_clk) begin
        if (rt_we) begin
            mem_rt[rt_waddr] <= rt_wdata;
        end
        r_rd <= mem_rt[rt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rq_we) begin
            mem_rq[r_q_tail] <= rq_wdata;
        end
        r_ring <= mem_rq[r_q_head];
    end

    assign scan_ctl.clear      = (r_state == ST_FIN);
    assign scan_ctl.go         = r_cmp_go;
    assign scan_ctl.first_only = (i_policy == MODE_FIFO);

    mjs_scan #(
        .MAX_JOBS   (MAX_JOBS),
        .BURST_BITS (BURST_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_idx   (r_cmp_idx),
        .i_used  (r_used[r_cmp_idx]),
        .i_value (r_rd),
        .o_found (scan_found),
        .o_best  (scan_best)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = is_tick ? ST_FIN : ST_OUT;
                end
            end
            ST_FIN: begin
                if (act_post && ((i_policy == MODE_FIFO) || (i_policy == MODE_SJF))) begin
                    n_state = ST_APPLY;
                end else if (i_policy == MODE_RR) begin
                    n_state = ST_RQ1;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_RQ1:   n_state = ST_RQ2;
            ST_RQ2:   n_state = rotate ? ST_RQ1 : ST_APPLY;
            ST_SCAN:  n_state = (r_scan == LAST_SLOT) ? ST_SEND : ST_SCAN;
            ST_SEND:  n_state = ST_SRES;
            ST_SRES:  n_state = ST_APPLY;
            ST_APPLY: n_state = ST_DEC;
            ST_DEC:   n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_used         <= '0;
            r_q_head       <= '0;
            r_q_tail       <= '0;
            r_q_count      <= '0;
            r_active_slot  <= '0;
            r_active_valid <= 1'b0;
            r_since        <= '0;
            r_jobs_loaded  <= '0;
            r_jobs_done    <= '0;
            r_scan         <= '0;
            r_cmp_go       <= 1'b0;
            r_rot_done     <= 1'b0;
            r_run          <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_go <= (r_state == ST_SCAN);
            unique case (r_state)
                ST_IDLE: begin
                    if (arr_ok) begin
                        r_used[slot_new] <= 1'b1;
                        r_jobs_loaded    <= CNT_W'(r_jobs_loaded + CNT_W'(1));
                        if ((i_policy == MODE_RR) && !q_full) begin
                            r_q_tail  <= wrap_inc(r_q_tail);
                            r_q_count <= CNT_W'(r_q_count + CNT_W'(1));
                        end
                    end
                end
                ST_FIN: begin
                    if (retire) begin
                        r_used[r_active_slot] <= 1'b0;
                        r_active_valid        <= 1'b0;
                        if (r_jobs_done != FULL_CNT) begin
                            r_jobs_done <= CNT_W'(r_jobs_done + CNT_W'(1));
                        end
                        if ((i_policy == MODE_RR) && (r_q_count != '0)) begin
                            r_q_head  <= wrap_inc(r_q_head);
                            r_q_count <= CNT_W'(r_q_count - CNT_W'(1));
                        end
                    end
                    r_run      <= 1'b1;
                    r_scan     <= '0;
                    r_rot_done <= 1'b0;
                end
                ST_RQ2: begin
                    if (rotate) begin
                        r_q_tail   <= wrap_inc(r_q_tail);
                        r_q_head   <= wrap_inc(r_q_head);
                        r_since    <= '0;
                        r_rot_done <= 1'b1;
                    end else begin
                        r_run <= (r_q_count != '0);
                    end
                end
                ST_SCAN: begin
                    if (r_scan != LAST_SLOT) begin
                        r_scan <= SLOT_W'(r_scan + SLOT_W'(1));
                    end
                end
                ST_SRES: begin
                    r_run <= scan_found;
                end
                ST_APPLY: begin
                    if (switched) begin
                        r_active_valid <= r_run;
                        r_active_slot  <= new_slot;
                        r_since        <= '0;
                    end
                end
                ST_DEC: begin
                    if (r_since != '1) begin
                        r_since <= QUANTUM_W'(r_since + QUANTUM_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_res <= idle_res;
                end
            end
            ST_FIN: begin
                if (retire) begin
                    r_res.finished      <= 1'b1;
                    r_res.finished_slot <= SLOT_FIELD_W'(r_active_slot);
                end
                r_pick <= r_active_slot;
            end
            ST_RQ2: begin
                r_pick <= r_ring;
            end
            ST_SRES: begin
                r_pick <= scan_best;
            end
            ST_APPLY: begin
                r_res.switched <= switched;
            end
            ST_DEC: begin
                r_res.slot       <= r_active_valid ? SLOT_FIELD_W'(r_active_slot) : '0;
                r_res.slot_valid <= r_active_valid;
                r_res.all_done   <= all_done_now;
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_OUT);
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/multi_policy_job_scheduler.sv @@
// Top level of the multi-policy job scheduler: configuration registers and
// the output register. Instantiates mjs_core. Depends on mjs_pkg.
//
//   Channel  Direction  Signals                                   Beat
//   in       in         i_in_valid / o_in_ready / i_in_beat        arrive or tick
//   out      out        o_out_valid / i_out_ready / o_out_beat     one result per input
//   cfg      in         i_cfg_we / i_cfg_index / i_cfg_data        register write
//
// An arrive beat goes from the idle to the output state. A tick beat passes the
// finish, apply, decrement and output states when a FIFO or SJF job keeps running;
// round robin adds the two ring states, twice when the queue rotates; else the
// compare unit walks the job table one slot per cycle for the first or the shortest
// job. The input is taken again while a result waits in the output register.
// Reset is synchronous and active low; there is no clearing pass.
`default_nettype none

module multi_policy_job_scheduler #(
    parameter int MAX_JOBS   = mjs_pkg::DEF_MAX_JOBS,
    parameter int BURST_BITS = mjs_pkg::DEF_BURST_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire mjs_pkg::t_in_beat                 i_in_beat,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output mjs_pkg::t_out_beat                     o_out_beat,
    input  wire logic                              i_cfg_we,
    input  wire logic [mjs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [mjs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mjs_pkg::*;

    logic [POLICY_W-1:0]  r_policy;
    logic [QUANTUM_W-1:0] r_quantum;
    logic [TOTAL_W-1:0]   r_job_total;
    logic                 r_out_valid;
    t_out_beat            r_out_beat;

    logic                 res_valid;
    logic                 res_ready;
    t_out_beat            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= MODE_FIFO;
            r_quantum   <= DEF_QUANTUM;
            r_job_total <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POLICY:  r_policy    <= i_cfg_data[POLICY_W-1:0];
                CFG_QUANTUM: r_quantum   <= i_cfg_data[QUANTUM_W-1:0];
                CFG_TOTAL:   r_job_total <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_beat <= res;
        end
    end

    mjs_core #(
        .MAX_JOBS   (MAX_JOBS),
        .BURST_BITS (BURST_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .i_policy    (r_policy),
        .i_quantum   (r_quantum),
        .i_job_total (r_job_total),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

@@ test/multi_policy_job_scheduler_check.sv @@
`timescale 1ns / 1ps
// Scoreboard for the multi-policy job scheduler: watches the job, result and register
// write ports, predicts every result beat and compares it field by field.
// Depends on mjs_pkg.
module multi_policy_job_scheduler_check
    import mjs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in_beat               i_in_beat,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_out_beat              i_out_beat,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_mismatch_count,
    output int                     o_pending
);

    localparam int JOBS = DEF_MAX_JOBS;
    localparam int SINCE_MAX = 65535;

    logic [POLICY_W-1:0]      mode;
    logic [QUANTUM_W-1:0]     quantum;
    logic [TOTAL_W-1:0]       job_total;
    logic [BURST_FIELD_W-1:0] time_left [JOBS];
    bit                       in_use [JOBS];
    logic [SLOT_FIELD_W-1:0]  rr_ring [JOBS];
    logic [SLOT_FIELD_W-1:0]  rr_head;
    logic [SLOT_FIELD_W-1:0]  rr_tail;
    int                       rr_count;
    logic [SLOT_FIELD_W-1:0]  run_slot;
    bit                       running;
    int                       since_switch;
    int                       jobs_loaded;
    int                       jobs_done;
    int                       mismatch_count = 0;
    t_out_beat                expected_beats [$];

    assign o_mismatch_count = mismatch_count;

    task automatic clear_schedule();
        mode = MODE_FIFO;
        quantum = DEF_QUANTUM;
        job_total = '0;
        for (int i = 0; i < JOBS; i++) begin
            time_left[i] = '0;
            in_use[i] = 1'b0;
            rr_ring[i] = '0;
        end
        rr_head = '0;
        rr_tail = '0;
        rr_count = 0;
        run_slot = '0;
        running = 1'b0;
        since_switch = 0;
        jobs_loaded = 0;
        jobs_done = 0;
    endtask

    task automatic choose_job(output bit found, output logic [SLOT_FIELD_W-1:0] pick);
        found = 1'b0;
        pick = '0;
        if (running && (mode == MODE_FIFO || mode == MODE_SJF)) begin
            found = 1'b1;
            pick = run_slot;
        end else if (mode == MODE_RR) begin
            if (running && rr_count > 0 && since_switch >= quantum) begin
                rr_ring[rr_tail] = rr_ring[rr_head];
                rr_tail++;
                rr_head++;
                since_switch = 0;
            end
            if (rr_count > 0) begin
                found = 1'b1;
                pick = rr_ring[rr_head];
            end
        end else begin
            for (int i = 0; i < JOBS; i++) begin
                if (in_use[i] && time_left[i] != 0) begin
                    if (mode == MODE_FIFO) begin
                        if (!found) begin
                            found = 1'b1;
                            pick = SLOT_FIELD_W'(i);
                        end
                    end else if (!found || time_left[i] < time_left[pick]) begin
                        found = 1'b1;
                        pick = SLOT_FIELD_W'(i);
                    end
                end
            end
        end
    endtask

    task automatic schedule_beat(input t_in_beat job, output t_out_beat res);
        bit                      found;
        logic [SLOT_FIELD_W-1:0] pick;
        res = '0;
        if (job.opcode == OP_ARRIVE) begin
            if (job.burst_length != 0) begin
                if (jobs_loaded >= JOBS) begin
                    res.table_full = 1'b1;
                end else begin
                    time_left[jobs_loaded] = job.burst_length;
                    in_use[jobs_loaded] = 1'b1;
                    if (mode == MODE_RR && rr_count < JOBS) begin
                        rr_ring[rr_tail] = SLOT_FIELD_W'(jobs_loaded);
                        rr_tail++;
                        rr_count++;
                    end
                    res.slot = SLOT_FIELD_W'(jobs_loaded);
                    res.slot_valid = 1'b1;
                    jobs_loaded++;
                end
            end
        end else begin
            if (running && time_left[run_slot] == 0) begin
                res.finished = 1'b1;
                res.finished_slot = run_slot;
                in_use[run_slot] = 1'b0;
                running = 1'b0;
                if (jobs_done < JOBS) jobs_done++;
                if (mode == MODE_RR && rr_count > 0) begin
                    rr_head++;
                    rr_count--;
                end
            end
            choose_job(found, pick);
            if (found != running || (found && pick != run_slot)) begin
                res.switched = 1'b1;
                running = found;
                run_slot = found ? pick : '0;
                since_switch = 0;
            end
            if (running) begin
                if (time_left[run_slot] != 0) time_left[run_slot]--;
                res.slot = run_slot;
                res.slot_valid = 1'b1;
            end
            if (since_switch < SINCE_MAX) since_switch++;
        end
        res.all_done = (jobs_done >= job_total);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_beat(input t_out_beat want, input t_out_beat got);
        check_field("slot", want.slot, got.slot);
        check_field("slot_valid", want.slot_valid, got.slot_valid);
        check_field("table_full", want.table_full, got.table_full);
        check_field("finished", want.finished, got.finished);
        check_field("finished_slot", want.finished_slot, got.finished_slot);
        check_field("switched", want.switched, got.switched);
        check_field("all_done", want.all_done, got.all_done);
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            clear_schedule();
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("Result beat arrived with no job beat waiting for it.");
                    mismatch_count++;
                end else begin
                    compare_beat(expected_beats.pop_front(), i_out_beat);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY: mode = i_cfg_data[POLICY_W-1:0];
                    CFG_QUANTUM: quantum = i_cfg_data[QUANTUM_W-1:0];
                    CFG_TOTAL: job_total = i_cfg_data[TOTAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                schedule_beat(i_in_beat, want);
                expected_beats.push_back(want);
            end
        end
        o_pending <= expected_beats.size();
    end

endmodule

@@ test/multi_policy_job_scheduler_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the multi-policy job scheduler: clock, reset, job and tick beats,
// register writes, random receiver stalls and the verdict.
// Depends on mjs_pkg, multi_policy_job_scheduler and multi_policy_job_scheduler_check.
module multi_policy_job_scheduler_test;
    import mjs_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 10;
    localparam int PHASE_BEATS    = 75;
    localparam int JOBS           = DEF_MAX_JOBS;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    t_in_beat               in_beat = '0;
    logic                   in_ready;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_beat              out_beat;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     mismatch_count;
    int                     pending;
    bit                     steady = 1'b0;
    bit                     squeeze = 1'b0;
    int                     jobs_sent = 0;
    int                     rx_stall = 0;
    int                     idle_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    multi_policy_job_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    multi_policy_job_scheduler_check u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_beat        (in_beat),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_beat       (out_beat),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge clk) begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
            idle_cycles++;
        end else begin
            idle_cycles = 0;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always begin
        @(negedge clk);
        if (squeeze) begin
            out_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge clk);
            squeeze = 1'b0;
        end
        if (steady) begin
            out_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            out_ready <= 1'b0;
            rx_stall--;
        end else if ($urandom_range(0, 3) != 0) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= 1'b0;
            rx_stall = gap_length();
        end
    end

    task automatic offer_beat(input t_in_beat beat);
        int gap;
        gap = (!steady && $urandom_range(0, 2) == 0) ? gap_length() : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic offer_arrival(input logic [BURST_FIELD_W-1:0] burst);
        t_in_beat beat;
        beat.opcode = OP_ARRIVE;
        beat.burst_length = burst;
        if (burst != 0) jobs_sent++;
        offer_beat(beat);
    endtask

    task automatic offer_tick();
        t_in_beat beat;
        beat.opcode = OP_TICK;
        beat.burst_length = BURST_FIELD_W'($urandom());
        offer_beat(beat);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= CFG_DATA_W'(value);
    endtask

    task automatic set_schedule(input logic [POLICY_W-1:0] mode, input int unsigned quantum,
                                input int unsigned total);
        drain();
        write_reg(CFG_POLICY, mode);
        write_reg(CFG_QUANTUM, quantum);
        write_reg(CFG_TOTAL, total);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [POLICY_W-1:0] mode;
        int unsigned         quantum;
        int unsigned         total;
        int                  quota;
        int                  pick;
        logic [BURST_FIELD_W-1:0] burst;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers: FIFO, and all jobs done from the start since the total is zero.
        offer_tick();
        offer_arrival('0);
        offer_arrival(1);
        offer_arrival(3);
        offer_arrival(2);
        offer_tick();
        offer_tick();

        // Zero-slice round robin strands FIFO jobs; a running job rotates if any is queued.
        set_schedule(MODE_RR, 0, 3);
        offer_arrival(2);
        offer_arrival(1);
        repeat (5) offer_tick();

        set_schedule(MODE_SJF, 16'hFFFF, JOBS);
        repeat (4) offer_tick();

        // Preemptive SJF picks the shortest job and, on equal bursts, the lowest slot.
        set_schedule(MODE_PSJF, 1, 5);
        offer_arrival(2);
        repeat (4) offer_tick();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: mode = MODE_FIFO;
                1: mode = MODE_RR;
                2: mode = MODE_SJF;
                default: mode = MODE_PSJF;
            endcase
            if (p >= 8) mode = POLICY_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 5);
            quantum = (pick == 0) ? 1 : (pick == 1) ? 16'hFFFF : $urandom_range(1, 6);
            total = (p == 1) ? JOBS : (p == 2) ? 0 : $urandom_range(0, JOBS);
            set_schedule(mode, quantum, total);
            steady = ($urandom_range(0, 3) == 0);
            if (p == 3) begin
                @(posedge clk);
                squeeze = 1'b1;
            end
            quota = $urandom_range(1, 2);
            if (quota > JOBS - 1 - jobs_sent) quota = JOBS - 1 - jobs_sent;
            repeat (PHASE_BEATS) begin
                if (quota > 0 && $urandom_range(0, 5) == 0) begin
                    pick = $urandom_range(0, 9);
                    burst = (pick == 0) ? '0 : (pick == 1) ? BURST_FIELD_W'($urandom_range(11, 60))
                                        : BURST_FIELD_W'($urandom_range(1, 10));
                    if (burst != 0) quota--;
                    offer_arrival(burst);
                end else begin
                    offer_tick();
                end
            end
        end

        // Last slot takes the longest burst; later arrivals find the table full.
        set_schedule(MODE_PSJF, $urandom_range(1, 6), JOBS);
        steady = 1'b0;
        while (jobs_sent < JOBS - 1) offer_arrival(BURST_FIELD_W'($urandom_range(1, 4)));
        offer_arrival({BURST_FIELD_W{1'b1}});
        repeat (60) begin
            if ($urandom_range(0, 2) == 0) offer_arrival(BURST_FIELD_W'($urandom()));
            else offer_tick();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
